[rtl/core/mqttp_pkg.sv]
// shared types and codes for the mqtt control packet parser
// field phases, tags, status codes, command nibbles and the item structs
`default_nettype none

package mqttp_pkg;

    localparam int unsigned MAX_LENGTH_BYTES = 4;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned TAG_W   = 5;

    // field phases
    localparam logic [PHASE_W-1:0] PH_HDR       = 5'd0;
    localparam logic [PHASE_W-1:0] PH_LEN       = 5'd1;
    localparam logic [PHASE_W-1:0] PH_PROTO_PFX = 5'd2;
    localparam logic [PHASE_W-1:0] PH_PROTO     = 5'd3;
    localparam logic [PHASE_W-1:0] PH_VER       = 5'd4;
    localparam logic [PHASE_W-1:0] PH_FLAGS     = 5'd5;
    localparam logic [PHASE_W-1:0] PH_KA        = 5'd6;
    localparam logic [PHASE_W-1:0] PH_CID_PFX   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_CID       = 5'd8;
    localparam logic [PHASE_W-1:0] PH_WT_PFX    = 5'd9;
    localparam logic [PHASE_W-1:0] PH_WT        = 5'd10;
    localparam logic [PHASE_W-1:0] PH_WM_PFX    = 5'd11;
    localparam logic [PHASE_W-1:0] PH_WM        = 5'd12;
    localparam logic [PHASE_W-1:0] PH_USER_PFX  = 5'd13;
    localparam logic [PHASE_W-1:0] PH_USER      = 5'd14;
    localparam logic [PHASE_W-1:0] PH_PW_PFX    = 5'd15;
    localparam logic [PHASE_W-1:0] PH_PW        = 5'd16;
    localparam logic [PHASE_W-1:0] PH_CDONE     = 5'd17;
    localparam logic [PHASE_W-1:0] PH_CA_FLAGS  = 5'd18;
    localparam logic [PHASE_W-1:0] PH_CA_CODE   = 5'd19;
    localparam logic [PHASE_W-1:0] PH_ID        = 5'd20;
    localparam logic [PHASE_W-1:0] PH_TOPIC_PFX = 5'd21;
    localparam logic [PHASE_W-1:0] PH_TOPIC     = 5'd22;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD   = 5'd23;
    localparam logic [PHASE_W-1:0] PH_OTHER     = 5'd24;
    localparam logic [PHASE_W-1:0] PH_COUNT     = 5'd25;

    // field tags
    localparam logic [TAG_W-1:0] TAG_HEADER   = 5'd0;
    localparam logic [TAG_W-1:0] TAG_LENGTH   = 5'd1;
    localparam logic [TAG_W-1:0] TAG_PREFIX   = 5'd2;
    localparam logic [TAG_W-1:0] TAG_PROTO    = 5'd3;
    localparam logic [TAG_W-1:0] TAG_VERSION  = 5'd4;
    localparam logic [TAG_W-1:0] TAG_FLAGS    = 5'd5;
    localparam logic [TAG_W-1:0] TAG_KEEP     = 5'd6;
    localparam logic [TAG_W-1:0] TAG_CLIENT   = 5'd7;
    localparam logic [TAG_W-1:0] TAG_WTOPIC   = 5'd8;
    localparam logic [TAG_W-1:0] TAG_WMSG     = 5'd9;
    localparam logic [TAG_W-1:0] TAG_USER     = 5'd10;
    localparam logic [TAG_W-1:0] TAG_PASSWORD = 5'd11;
    localparam logic [TAG_W-1:0] TAG_MSG_ID   = 5'd12;
    localparam logic [TAG_W-1:0] TAG_TOPIC    = 5'd13;
    localparam logic [TAG_W-1:0] TAG_PAYLOAD  = 5'd14;
    localparam logic [TAG_W-1:0] TAG_CONNACK  = 5'd15;
    localparam logic [TAG_W-1:0] TAG_OTHER    = 5'd16;
    localparam logic [TAG_W-1:0] TAG_DISCARD  = 5'd17;

    // status codes
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_MALF = 2'd2;

    // command nibbles
    localparam logic [3:0] CMD_CONNECT   = 4'd1;
    localparam logic [3:0] CMD_CONNACK   = 4'd2;
    localparam logic [3:0] CMD_PUBLISH   = 4'd3;
    localparam logic [3:0] CMD_PUBACK    = 4'd4;
    localparam logic [3:0] CMD_PUBREC    = 4'd5;
    localparam logic [3:0] CMD_PUBREL    = 4'd6;
    localparam logic [3:0] CMD_PUBCOMP   = 4'd7;
    localparam logic [3:0] CMD_SUBSCRIBE = 4'd8;
    localparam logic [3:0] CMD_SUBACK    = 4'd9;

    // connect flag bit positions
    localparam int unsigned FLAG_WILL_BIT = 2;
    localparam int unsigned FLAG_PASS_BIT = 6;
    localparam int unsigned FLAG_USER_BIT = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_over;
    } mqttp_item_t;

    typedef struct packed {
        logic [7:0]       data_out;
        logic [TAG_W-1:0] field_tag;
        logic             field_first;
        logic [3:0]       msg_cmd;
        logic [1:0]       msg_qos;
        logic [1:0]       status;
        logic [15:0]      packet_id;
        logic [15:0]      keepalive_secs;
        logic [7:0]       connect_flag_bits;
        logic [7:0]       protocol_level;
        logic [7:0]       connack_code;
        logic [28:0]      total_length;
    } mqttp_result_t;

    function automatic logic [TAG_W-1:0] phase_tag(input logic [PHASE_W-1:0] ph);
        logic [TAG_W-1:0] t;
        case (ph)
            PH_HDR:       t = TAG_HEADER;
            PH_LEN:       t = TAG_LENGTH;
            PH_PROTO_PFX: t = TAG_PREFIX;
            PH_PROTO:     t = TAG_PROTO;
            PH_VER:       t = TAG_VERSION;
            PH_FLAGS:     t = TAG_FLAGS;
            PH_KA:        t = TAG_KEEP;
            PH_CID_PFX:   t = TAG_PREFIX;
            PH_CID:       t = TAG_CLIENT;
            PH_WT_PFX:    t = TAG_PREFIX;
            PH_WT:        t = TAG_WTOPIC;
            PH_WM_PFX:    t = TAG_PREFIX;
            PH_WM:        t = TAG_WMSG;
            PH_USER_PFX:  t = TAG_PREFIX;
            PH_USER:      t = TAG_USER;
            PH_PW_PFX:    t = TAG_PREFIX;
            PH_PW:        t = TAG_PASSWORD;
            PH_CDONE:     t = TAG_OTHER;
            PH_CA_FLAGS:  t = TAG_OTHER;
            PH_CA_CODE:   t = TAG_CONNACK;
            PH_ID:        t = TAG_MSG_ID;
            PH_TOPIC_PFX: t = TAG_PREFIX;
            PH_TOPIC:     t = TAG_TOPIC;
            PH_PAYLOAD:   t = TAG_PAYLOAD;
            default:      t = TAG_OTHER;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mqtt_packet_parser.sv]
// mqtt control packet parser, top level: input register, field machine, result register
// depends on mqttp_pkg and mqttp_field_core
//
// usage:
//   s_axis carries the received stream one byte per item; tuser is start_over,
//   which clears the parser and any error and makes this byte a header byte.
//   m_axis returns exactly one item per input byte: the byte, its field tag,
//   a first-of-field flag, the header command and qos, a status (in progress,
//   message complete on this byte, malformed) and the fields collected so far.
//   a result item becomes valid once its input item is accepted and has passed
//   the input register and the result register; throughput is one byte per cycle
//   while the receiver is ready, with a combinational field decode between the two.
//   after a malformed message every byte comes back tagged discarded until a
//   byte arrives with start_over set.
//   reset returns the parser to waiting for a header byte with all collected
//   fields zero and both channel registers empty.
//   when the receiver stalls, the result register holds its item and the input
//   register can still take one more byte; s_axis_tready then drops until
//   m_axis_tready rises again.
`default_nettype none

module mqtt_packet_parser
    import mqttp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data_byte
    input  wire logic         s_axis_tuser,   // start_over

    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // data_out, msg_cmd, msg_qos, status, packet_id, keepalive_secs,
    // connect_flag_bits, protocol_level, connack_code, total_length, zero fill
    output      logic [103:0] m_axis_tdata,
    output      logic [5:0]   m_axis_tuser    // field_tag, field_first
);

    logic          in_valid_reg;
    mqttp_item_t   in_item_reg;
    logic          out_valid_reg;
    mqttp_result_t out_reg;
    mqttp_result_t result;
    logic          advance;
    logic          step;
    logic          s_accept;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data_byte  <= s_axis_tdata;
            in_item_reg.start_over <= s_axis_tuser;
        end
    end

    mqttp_field_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0,
                            out_reg.total_length,
                            out_reg.connack_code,
                            out_reg.protocol_level,
                            out_reg.connect_flag_bits,
                            out_reg.keepalive_secs,
                            out_reg.packet_id,
                            out_reg.status,
                            out_reg.msg_qos,
                            out_reg.msg_cmd,
                            out_reg.data_out};
    assign m_axis_tuser  = {out_reg.field_first, out_reg.field_tag};

endmodule

`default_nettype wire

[rtl/core/mqttp_field_core.sv]
// field machine of the mqtt control packet parser: parse state and per-byte decode
// depends on mqttp_pkg for phases, tags, status codes and item structs
`default_nettype none

module mqttp_field_core
    import mqttp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire mqttp_item_t   item,
    output mqttp_result_t      result
);

    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic               started_reg,   started_next;
    logic               error_reg,     error_next;
    logic [7:0]         header_reg,    header_next;
    logic [27:0]        len_acc_reg,   len_acc_next;
    logic [2:0]         len_cnt_reg,   len_cnt_next;
    logic [27:0]        left_reg,      left_next;
    logic [15:0]        str_reg,       str_next;
    logic [7:0]         flags_reg,     flags_next;
    logic [7:0]         version_reg,   version_next;
    logic [15:0]        keep_reg,      keep_next;
    logic [15:0]        msg_id_reg,    msg_id_next;
    logic [7:0]         connack_reg,   connack_next;
    logic [28:0]        msg_bytes_reg, msg_bytes_next;

    logic [7:0]         b;
    logic [TAG_W-1:0]   tag;
    logic               first;
    logic [1:0]         status;
    logic [27:0]        len_add;
    logic [27:0]        len_sum;
    logic [2:0]         cnt_inc;
    logic [PHASE_W-1:0] body_ph;
    logic [15:0]        str_or;
    logic [15:0]        str_dec;
    logic [27:0]        left_dec;

    function automatic logic [PHASE_W-1:0] after_wm(input logic [7:0] flags);
        logic [PHASE_W-1:0] p;
        if (flags[FLAG_USER_BIT]) begin
            p = PH_USER_PFX;
        end else if (flags[FLAG_PASS_BIT]) begin
            p = PH_PW_PFX;
        end else begin
            p = PH_CDONE;
        end
        return p;
    endfunction

    function automatic logic [PHASE_W-1:0] after_field(input logic [PHASE_W-1:0] ph,
                                                       input logic [7:0] flags,
                                                       input logic [7:0] hdr);
        logic [PHASE_W-1:0] p;
        case (ph)
            PH_PROTO: p = PH_VER;
            PH_CID:   p = flags[FLAG_WILL_BIT] ? PH_WT_PFX : after_wm(flags);
            PH_WT:    p = PH_WM_PFX;
            PH_WM:    p = after_wm(flags);
            PH_USER:  p = flags[FLAG_PASS_BIT] ? PH_PW_PFX : PH_CDONE;
            PH_PW:    p = PH_CDONE;
            PH_TOPIC: p = (hdr[2:1] != 2'd0) ? PH_ID : PH_PAYLOAD;
            PH_ID:    p = (hdr[7:4] == CMD_PUBLISH || hdr[7:4] == CMD_SUBSCRIBE)
                          ? PH_PAYLOAD : PH_OTHER;
            default:  p = PH_OTHER;
        endcase
        return p;
    endfunction

    function automatic logic [PHASE_W-1:0] body_start(input logic [3:0] cmd);
        logic [PHASE_W-1:0] p;
        case (cmd)
            CMD_CONNECT:   p = PH_PROTO_PFX;
            CMD_CONNACK:   p = PH_CA_FLAGS;
            CMD_PUBLISH:   p = PH_TOPIC_PFX;
            CMD_PUBACK,
            CMD_PUBREC,
            CMD_PUBREL,
            CMD_PUBCOMP,
            CMD_SUBSCRIBE,
            CMD_SUBACK:    p = PH_ID;
            default:       p = PH_OTHER;
        endcase
        return p;
    endfunction

    assign b = item.data_byte;

    always_comb begin
        case (len_cnt_reg[1:0])
            2'd0:    len_add = {21'd0, b[6:0]};
            2'd1:    len_add = {14'd0, b[6:0], 7'd0};
            2'd2:    len_add = {7'd0, b[6:0], 14'd0};
            default: len_add = {b[6:0], 21'd0};
        endcase
    end

    assign len_sum  = len_acc_reg + len_add;
    assign cnt_inc  = len_cnt_reg + 3'd1;
    assign body_ph  = body_start(header_reg[7:4]);
    assign str_or   = str_reg | {8'd0, b};
    assign str_dec  = (str_reg != 16'd0) ? str_reg - 16'd1 : str_reg;
    assign left_dec = (left_reg != 28'd0) ? left_reg - 28'd1 : left_reg;

    always_comb begin
        phase_next     = phase_reg;
        started_next   = started_reg;
        error_next     = error_reg;
        header_next    = header_reg;
        len_acc_next   = len_acc_reg;
        len_cnt_next   = len_cnt_reg;
        left_next      = left_reg;
        str_next       = str_reg;
        flags_next     = flags_reg;
        version_next   = version_reg;
        keep_next      = keep_reg;
        msg_id_next    = msg_id_reg;
        connack_next   = connack_reg;
        msg_bytes_next = msg_bytes_reg;
        tag            = TAG_DISCARD;
        first          = 1'b0;
        status         = ST_BUSY;

        if (item.start_over ||
            (!error_reg && (phase_reg == PH_HDR || phase_reg >= PH_COUNT))) begin
            // header byte: everything restarts from this byte
            tag            = TAG_HEADER;
            first          = 1'b1;
            phase_next     = PH_LEN;
            started_next   = 1'b0;
            error_next     = 1'b0;
            header_next    = b;
            len_acc_next   = 28'd0;
            len_cnt_next   = 3'd0;
            left_next      = 28'd0;
            str_next       = 16'd0;
            flags_next     = 8'd0;
            version_next   = 8'd0;
            keep_next      = 16'd0;
            msg_id_next    = 16'd0;
            connack_next   = 8'd0;
            msg_bytes_next = 29'd0;
        end else if (error_reg) begin
            tag = TAG_DISCARD;
        end else if (phase_reg == PH_LEN) begin
            tag          = TAG_LENGTH;
            first        = (len_cnt_reg == 3'd0);
            len_acc_next = len_sum;
            len_cnt_next = cnt_inc;
            if (b[7]) begin
                if (cnt_inc >= 3'(MAX_LENGTH_BYTES)) begin
                    status       = ST_MALF;
                    error_next   = 1'b1;
                    phase_next   = PH_HDR;
                    started_next = 1'b0;
                end
            end else begin
                msg_bytes_next = 29'd1 + {26'd0, cnt_inc} + {1'b0, len_sum};
                left_next      = len_sum;
                phase_next     = body_ph;
                started_next   = 1'b0;
                if (len_sum == 28'd0) begin
                    // empty body
                    if (body_ph == PH_OTHER) begin
                        status = ST_DONE;
                    end else begin
                        status     = ST_MALF;
                        error_next = 1'b1;
                    end
                    phase_next = PH_HDR;
                end
            end
        end else begin
            tag   = phase_tag(phase_reg);
            first = !started_reg;
            case (phase_reg)
                PH_PROTO_PFX, PH_CID_PFX, PH_WT_PFX, PH_WM_PFX,
                PH_USER_PFX, PH_PW_PFX, PH_TOPIC_PFX: begin
                    if (!started_reg) begin
                        str_next     = {b, 8'd0};
                        started_next = 1'b1;
                    end else begin
                        str_next     = str_or;
                        started_next = 1'b0;
                        phase_next   = (str_or != 16'd0) ? phase_reg + 5'd1
                                       : after_field(phase_reg + 5'd1, flags_reg, header_reg);
                    end
                end
                PH_PROTO, PH_CID, PH_WT, PH_WM, PH_USER, PH_PW, PH_TOPIC: begin
                    str_next = str_dec;
                    if (str_dec == 16'd0) begin
                        phase_next   = after_field(phase_reg, flags_reg, header_reg);
                        started_next = 1'b0;
                    end else begin
                        started_next = 1'b1;
                    end
                end
                PH_VER: begin
                    version_next = b;
                    phase_next   = PH_FLAGS;
                    started_next = 1'b0;
                end
                PH_FLAGS: begin
                    flags_next   = b;
                    phase_next   = PH_KA;
                    started_next = 1'b0;
                end
                PH_KA: begin
                    if (!started_reg) begin
                        keep_next    = {b, 8'd0};
                        started_next = 1'b1;
                    end else begin
                        keep_next    = keep_reg | {8'd0, b};
                        phase_next   = PH_CID_PFX;
                        started_next = 1'b0;
                    end
                end
                PH_CA_FLAGS: begin
                    phase_next   = PH_CA_CODE;
                    started_next = 1'b0;
                end
                PH_CA_CODE: begin
                    connack_next = b;
                    phase_next   = PH_OTHER;
                    started_next = 1'b0;
                end
                PH_ID: begin
                    if (!started_reg) begin
                        msg_id_next  = {b, 8'd0};
                        started_next = 1'b1;
                    end else begin
                        msg_id_next  = msg_id_reg | {8'd0, b};
                        phase_next   = after_field(PH_ID, flags_reg, header_reg);
                        started_next = 1'b0;
                    end
                end
                PH_CDONE: begin
                    // byte after the last connect string
                    status     = ST_MALF;
                    error_next = 1'b1;
                end
                default: begin
                    started_next = 1'b1;
                end
            endcase

            if (status == ST_BUSY) begin
                left_next = left_dec;
                if (left_dec == 28'd0) begin
                    if (phase_next == PH_CDONE || phase_next == PH_PAYLOAD ||
                        phase_next == PH_OTHER) begin
                        status = ST_DONE;
                    end else begin
                        status     = ST_MALF;
                        error_next = 1'b1;
                    end
                    phase_next   = PH_HDR;
                    started_next = 1'b0;
                end
            end else begin
                phase_next   = PH_HDR;
                started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR;
            started_reg   <= 1'b0;
            error_reg     <= 1'b0;
            header_reg    <= 8'd0;
            len_acc_reg   <= 28'd0;
            len_cnt_reg   <= 3'd0;
            left_reg      <= 28'd0;
            str_reg       <= 16'd0;
            flags_reg     <= 8'd0;
            version_reg   <= 8'd0;
            keep_reg      <= 16'd0;
            msg_id_reg    <= 16'd0;
            connack_reg   <= 8'd0;
            msg_bytes_reg <= 29'd0;
        end else if (step) begin
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            error_reg     <= error_next;
            header_reg    <= header_next;
            len_acc_reg   <= len_acc_next;
            len_cnt_reg   <= len_cnt_next;
            left_reg      <= left_next;
            str_reg       <= str_next;
            flags_reg     <= flags_next;
            version_reg   <= version_next;
            keep_reg      <= keep_next;
            msg_id_reg    <= msg_id_next;
            connack_reg   <= connack_next;
            msg_bytes_reg <= msg_bytes_next;
        end
    end

    always_comb begin
        result.data_out          = b;
        result.field_tag         = tag;
        result.field_first       = first;
        result.msg_cmd           = header_next[7:4];
        result.msg_qos           = header_next[2:1];
        result.status            = status;
        result.packet_id         = msg_id_next;
        result.keepalive_secs    = keep_next;
        result.connect_flag_bits = flags_next;
        result.protocol_level    = version_next;
        result.connack_code      = connack_next;
        result.total_length      = msg_bytes_next;
    end

endmodule

`default_nettype wire
